// ----- hdl/rfsm_pkg.sv -----
// shared types, constants and register codes for the record filter
package rfsm_pkg;

  localparam int DEF_MAX_RECORD  = 8192;
  localparam int DEF_MAX_LINE    = 4096;
  localparam int DEF_MATCH_BYTES = 8;

  localparam int RESULT_LEN_W = 14;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int LEN_W        = 4;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RECORD_MODE    = 3'd0,
    REG_KEY_BYTES      = 3'd1,
    REG_KEY_LENGTH     = 3'd2,
    REG_PATTERN_BYTES  = 3'd3,
    REG_PATTERN_LENGTH = 3'd4,
    REG_PREFIX_BYTES   = 3'd5,
    REG_PREFIX_LENGTH  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } byte_item_t;

  typedef struct packed {
    logic                    matched;
    logic [RESULT_LEN_W-1:0] record_length;
    logic                    last_of_run;
  } result_t;

endpackage

// ----- hdl/record_filter_substring_match_top.sv -----
// streaming substring record filter: record split, key/pattern/prefix tests, result queue
//
//   channel | handshake                 | payload
//   --------+---------------------------+--------------------------------------
//   byte    | byte_valid / byte_stall   | byte_data   (text_byte, end_of_input)
//   result  | result_valid / result_stall | result_data (matched, record_length,
//           |                           |              last_of_run)
//   cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one byte per clock while the queue has room: a byte is held in the input register, then the
// record update and the match tests run combinationally into a 4-entry result queue.
// a byte that closes two records (record mode, key on the final byte) puts two
// results in the queue; the input register waits while fewer than two slots are free.
// synchronous active-high reset clears stream state, queue and registers to defaults.
// result_stall only backs up the queue; byte_stall rises when the queue is near full.
module record_filter_substring_match_top
  import rfsm_pkg::*;
#(
  parameter int MAX_RECORD  = DEF_MAX_RECORD,
  parameter int MAX_LINE    = DEF_MAX_LINE,
  parameter int MATCH_BYTES = DEF_MATCH_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  byte_item_t             byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MB       = MATCH_BYTES;
  localparam int HIST     = 2 * MB;
  localparam int HW       = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int MAXC     = (MAX_RECORD > MAX_LINE - 1) ? MAX_RECORD : MAX_LINE - 1;
  localparam int CW       = $clog2(MAXC + 1);
  localparam int KSW      = (MB > 1) ? $clog2(MB) : 1;
  localparam int NSW      = $clog2(MB + 1);
  localparam int FD       = 4;
  localparam int PW       = $clog2(FD);
  localparam int FCW      = $clog2(FD + 1);

  typedef logic [HIST-1:0][7:0] hist_t;

  // configuration registers
  logic                  record_mode;
  logic [CFG_DATA_W-1:0] key_bytes;
  logic [LEN_W-1:0]      key_length;
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] prefix_bytes;
  logic [LEN_W-1:0]      prefix_length;

  // stream state
  hist_t          hist;
  logic [CW-1:0]  record_count;
  logic           pattern_seen;
  logic           prefix_good;
  logic           inside_record;
  logic [KSW-1:0] key_skip_count;
  logic           nul_seen;
  logic           over_limit;

  // input register
  logic       s1_valid;
  byte_item_t s1;

  // result queue
  result_t        queue [FD];
  logic [PW-1:0]  rd_ptr;
  logic [PW-1:0]  wr_ptr;
  logic [FCW-1:0] fill;

  // datapath
  logic           advance;
  logic           pop;
  logic [7:0]     b_in;
  hist_t          hist_next;
  logic [LEN_W-1:0] klen;
  logic [LEN_W-1:0] nlen;
  logic [LEN_W-1:0] plen;
  logic [KSW-1:0] dlen;
  logic           key_hit;
  logic [KSW-1:0] key_skip_count_next;
  logic [CW-1:0]  record_count_next;
  logic           pattern_seen_next;
  logic           prefix_good_next;
  logic           inside_record_next;
  logic           nul_seen_next;
  logic           over_limit_next;
  logic           do_take;
  logic [HW-1:0]  start_age;
  logic [NSW-1:0] nsteps;
  logic [CW:0]    cap;
  logic [CW:0]    sum;
  logic [CW:0]    cj;
  logic [HW-1:0]  age;
  logic [7:0]     bj;
  logic [2:0]     pidx;
  logic           a_valid;
  logic           b_valid;
  result_t        res_a;
  result_t        res_b;
  result_t        r0;
  result_t        r1;
  logic [1:0]     npush;

  // ref byte i against history byte at age + len - 1 - i
  function automatic logic hist_match(hist_t h, logic [CFG_DATA_W-1:0] r,
                                      logic [LEN_W-1:0] len, logic [HW-1:0] a);
    logic        ok;
    logic [HW:0] idx;
    ok = 1'b1;
    for (int i = 0; i < MB; i++) begin
      idx = '0;
      if (LEN_W'(i) < len) begin
        idx = (HW+1)'(a) + (HW+1)'(len) - (HW+1)'(i) - (HW+1)'(1);
        if (h[idx[HW-1:0]] != r[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic result_t finish_res(logic ps, logic pg, logic [CW-1:0] cnt,
                                         logic mode, logic [LEN_W-1:0] n,
                                         logic [LEN_W-1:0] pl);
    result_t r;
    logic    ok;
    ok = (n == '0) || ps;
    if (!mode && pl != '0 && !(pg && cnt >= CW'(pl))) ok = 1'b0;
    r.matched       = ok;
    r.record_length = RESULT_LEN_W'(cnt);
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_mode    <= 1'b0;
      key_bytes      <= '0;
      key_length     <= LEN_W'(1);
      pattern_bytes  <= '0;
      pattern_length <= '0;
      prefix_bytes   <= '0;
      prefix_length  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RECORD_MODE:    record_mode    <= cfg_data[0];
        REG_KEY_BYTES:      key_bytes      <= cfg_data;
        REG_KEY_LENGTH:     key_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_PREFIX_BYTES:   prefix_bytes   <= cfg_data;
        REG_PREFIX_LENGTH:  prefix_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // effective lengths
  always_comb begin
    if (key_length == '0) klen = LEN_W'(1);
    else if (key_length > LEN_W'(MB)) klen = LEN_W'(MB);
    else klen = key_length;
    nlen = (pattern_length > LEN_W'(MB)) ? LEN_W'(MB) : pattern_length;
    plen = (prefix_length > LEN_W'(MB)) ? LEN_W'(MB) : prefix_length;
    dlen = KSW'(klen - LEN_W'(1));
  end

  assign advance    = s1_valid && (fill <= FCW'(FD - 2));
  assign byte_stall = s1_valid && !advance;
  assign pop        = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (byte_valid && !byte_stall) || (s1_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1 <= byte_data;
    end
  end

  // record update for the byte in the input register
  always_comb begin
    b_in = s1.text_byte;
    if (record_mode && b_in == CHAR_NUL) b_in = CHAR_SPACE;
    hist_next = {hist[HIST-2:0], b_in};

    key_hit             = 1'b0;
    key_skip_count_next = key_skip_count;
    record_count_next   = record_count;
    pattern_seen_next   = pattern_seen;
    prefix_good_next    = prefix_good;
    inside_record_next  = inside_record;
    nul_seen_next       = nul_seen;
    over_limit_next     = over_limit;
    a_valid             = 1'b0;
    b_valid             = 1'b0;
    res_a               = '0;
    res_b               = '0;
    do_take             = 1'b0;
    start_age           = '0;
    nsteps              = NSW'(1);
    cap                 = record_mode ? (CW+1)'(MAX_RECORD) : (CW+1)'(MAX_LINE - 1);
    sum                 = '0;
    cj                  = '0;
    age                 = '0;
    bj                  = '0;
    pidx                = '0;

    if (record_mode) begin
      if (key_skip_count != '0) begin
        key_skip_count_next = key_skip_count - KSW'(1);
      end else begin
        key_hit = hist_match(hist_next, key_bytes, klen, '0);
      end
      if (key_hit) begin
        if (inside_record) begin
          res_a   = finish_res(pattern_seen, prefix_good, record_count, record_mode,
                               nlen, plen);
          a_valid = 1'b1;
        end
        record_count_next   = '0;
        pattern_seen_next   = 1'b0;
        prefix_good_next    = 1'b1;
        nul_seen_next       = 1'b0;
        over_limit_next     = 1'b0;
        inside_record_next  = 1'b1;
        key_skip_count_next = dlen;
      end
      do_take   = inside_record_next;
      start_age = HW'(dlen);
      // at end of input the bytes still held back behind the key are taken too
      nsteps    = s1.end_of_input ? NSW'(dlen) + NSW'(1) : NSW'(1);
    end else begin
      if (!inside_record) begin
        record_count_next  = '0;
        pattern_seen_next  = 1'b0;
        prefix_good_next   = 1'b1;
        nul_seen_next      = 1'b0;
        over_limit_next    = 1'b0;
        inside_record_next = 1'b1;
      end
      do_take = 1'b1;
    end

    // take bytes from age start_age downward; once one hits the cap the rest do too
    if (do_take) begin
      for (int j = 0; j < MB; j++) begin
        if (NSW'(j) < nsteps) begin
          sum = (CW+1)'(record_count_next) + (CW+1)'(j);
          if (sum < cap) begin
            cj   = sum + (CW+1)'(1);
            age  = start_age - HW'(j);
            bj   = hist_next[age];
            pidx = 3'(cj - (CW+1)'(1));
            if (bj == CHAR_NUL) nul_seen_next = 1'b1;
            if (cj <= (CW+1)'(plen) &&
                (nul_seen_next || bj != prefix_bytes[8*pidx +: 8])) begin
              prefix_good_next = 1'b0;
            end
            if (!nul_seen_next && nlen != '0 && cj >= (CW+1)'(nlen) &&
                hist_match(hist_next, pattern_bytes, nlen, age)) begin
              pattern_seen_next = 1'b1;
            end
          end else begin
            over_limit_next = 1'b1;
          end
        end
      end
      for (int j = 0; j < MB; j++) begin
        if (NSW'(j) < nsteps &&
            (CW+1)'(record_count_next) + (CW+1)'(j) < cap) begin
          cj = (CW+1)'(record_count_next) + (CW+1)'(j) + (CW+1)'(1);
        end
      end
      if ((CW+1)'(record_count_next) < cap) record_count_next = CW'(cj);
    end

    if (record_mode) begin
      if (s1.end_of_input && inside_record_next) begin
        res_b   = finish_res(pattern_seen_next, prefix_good_next, record_count_next,
                             record_mode, nlen, plen);
        b_valid = 1'b1;
      end
    end else begin
      if (b_in == CHAR_NEWLINE || s1.end_of_input ||
          (CW+1)'(record_count_next) >= (CW+1)'(MAX_LINE - 1)) begin
        res_b              = finish_res(pattern_seen_next, prefix_good_next,
                                        record_count_next, record_mode, nlen, plen);
        b_valid            = 1'b1;
        inside_record_next = 1'b0;
      end
    end

    if (s1.end_of_input) begin
      hist_next           = '0;
      record_count_next   = '0;
      pattern_seen_next   = 1'b0;
      prefix_good_next    = 1'b0;
      inside_record_next  = 1'b0;
      key_skip_count_next = '0;
      nul_seen_next       = 1'b0;
      over_limit_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist           <= '0;
      record_count   <= '0;
      pattern_seen   <= 1'b0;
      prefix_good    <= 1'b0;
      inside_record  <= 1'b0;
      key_skip_count <= '0;
      nul_seen       <= 1'b0;
      over_limit     <= 1'b0;
    end else if (advance) begin
      hist           <= hist_next;
      record_count   <= record_count_next;
      pattern_seen   <= pattern_seen_next;
      prefix_good    <= prefix_good_next;
      inside_record  <= inside_record_next;
      key_skip_count <= key_skip_count_next;
      nul_seen       <= nul_seen_next;
      over_limit     <= over_limit_next;
    end
  end

  // order the results of this byte and mark the last one
  always_comb begin
    r0 = a_valid ? res_a : res_b;
    r0.last_of_run = !(a_valid && b_valid);
    r1 = res_b;
    r1.last_of_run = 1'b1;
    npush = 2'(a_valid) + 2'(b_valid);
    if (!advance) npush = '0;
  end

  always_ff @(posedge clk) begin
    if (npush != '0) queue[wr_ptr] <= r0;
    if (npush == 2'd2) queue[wr_ptr + PW'(1)] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(npush);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + FCW'(npush) - FCW'(pop);
    end
  end

  assign result_valid = (fill != '0);
  assign result_data  = queue[rd_ptr];

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the record filter: byte stream stimulus, record prediction and result checks
module tb;
  import rfsm_pkg::*;

  localparam int unsigned REC_CAP         = DEF_MAX_RECORD;
  localparam int unsigned LINE_CAP        = DEF_MAX_LINE - 1;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam longint      TIMEOUT         = 24_000_000;
  localparam bit          MODE_LINE       = 1'b0;
  localparam bit          MODE_RECORD     = 1'b1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_stall;
  byte_item_t             byte_data = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_RECORD_MODE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  record_filter_substring_match_top dut (
    .clk, .rst,
    .byte_valid, .byte_stall, .byte_data,
    .result_valid, .result_stall, .result_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter settings as the block should hold them
  bit        cfg_mode;
  bit [63:0] cfg_key, cfg_pat, cfg_pfx;
  bit [3:0]  cfg_key_len, cfg_pat_len, cfg_pfx_len;

  // stream state of the predicted filter
  bit [63:0]   recent_bytes;
  bit [7:0]    older_bytes [8];
  int unsigned kept_count;
  bit          pat_found, pfx_ok, in_record, nul_found, capped;
  int unsigned key_skip;

  byte_item_t  byte_queue [$];
  result_t     pending_records [$];
  int unsigned queued_count, accepted_count, error_count;
  bit          byte_taken;
  bit          long_stall_req;

  function automatic int unsigned eff_len(bit [3:0] v, int unsigned lo);
    int unsigned top;
    top = (DEF_MATCH_BYTES > 8) ? 8 : DEF_MATCH_BYTES;
    if (v < lo) return lo;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic bit [7:0] hist_byte(int unsigned age);
    age = age & 15;
    if (age < 8) return recent_bytes[8*age +: 8];
    return older_bytes[age-8];
  endfunction

  function automatic void shift_in(bit [7:0] b);
    for (int i = 7; i > 0; i--) older_bytes[i] = older_bytes[i-1];
    older_bytes[0] = recent_bytes[63:56];
    recent_bytes = {recent_bytes[55:0], b};
  endfunction

  // word byte i is compared with the history byte at age + len - 1 - i
  function automatic bit seq_hit(bit [63:0] w, int unsigned len, int unsigned age);
    for (int unsigned i = 0; i < len; i++)
      if (w[8*i +: 8] != hist_byte(age + len - 1 - i)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void begin_record();
    kept_count = 0;
    pat_found  = 1'b0;
    pfx_ok     = 1'b1;
    nul_found  = 1'b0;
    capped     = 1'b0;
    in_record  = 1'b1;
  endfunction

  function automatic void clear_stream();
    recent_bytes = '0;
    foreach (older_bytes[i]) older_bytes[i] = '0;
    kept_count = 0;
    pat_found  = 1'b0;
    pfx_ok     = 1'b0;
    in_record  = 1'b0;
    key_skip   = 0;
    nul_found  = 1'b0;
    capped     = 1'b0;
  endfunction

  function automatic void count_byte(int unsigned age);
    bit [7:0]    b;
    int unsigned lim, pl, n;
    b   = hist_byte(age);
    lim = cfg_mode ? REC_CAP : LINE_CAP;
    pl  = eff_len(cfg_pfx_len, 0);
    n   = eff_len(cfg_pat_len, 0);
    if (kept_count >= lim) begin
      capped = 1'b1;
      return;
    end
    kept_count++;
    if (b == CHAR_NUL) nul_found = 1'b1;
    if (kept_count <= pl && (nul_found || b != cfg_pfx[8*(kept_count-1) +: 8]))
      pfx_ok = 1'b0;
    if (!nul_found && n > 0 && kept_count >= n && seq_hit(cfg_pat, n, age))
      pat_found = 1'b1;
  endfunction

  function automatic void close_record();
    result_t     r;
    int unsigned n, pl;
    bit          ok;
    n  = eff_len(cfg_pat_len, 0);
    pl = eff_len(cfg_pfx_len, 0);
    ok = (n == 0) || pat_found;
    if (!cfg_mode && pl > 0 && !(pfx_ok && kept_count >= pl)) ok = 1'b0;
    r.matched       = ok;
    r.record_length = kept_count[RESULT_LEN_W-1:0];
    r.last_of_run   = 1'b0;
    pending_records.push_back(r);
    in_record = 1'b0;
  endfunction

  function automatic void filter_byte(byte_item_t it);
    bit [7:0]    b;
    int unsigned len, d, produced;
    bit          key_hit;
    b        = it.text_byte;
    produced = 0;
    key_hit  = 1'b0;
    if (cfg_mode) begin
      len = eff_len(cfg_key_len, 1);
      d   = len - 1;
      if (b == CHAR_NUL) b = CHAR_SPACE;
      shift_in(b);
      if (key_skip > 0) key_skip--;
      else key_hit = seq_hit(cfg_key, len, 0);
      if (key_hit) begin
        if (in_record) begin
          close_record();
          produced++;
        end
        begin_record();
        key_skip = d;
      end
      if (in_record) count_byte(d);
      if (it.end_of_input) begin
        if (in_record) begin
          // key bytes still held back join the record
          for (int unsigned a = d; a > 0; a--) count_byte(a - 1);
          close_record();
          produced++;
        end
        clear_stream();
      end
    end else begin
      shift_in(b);
      if (!in_record) begin_record();
      count_byte(0);
      if (b == CHAR_NEWLINE || kept_count >= LINE_CAP || it.end_of_input) begin
        close_record();
        produced++;
      end
      if (it.end_of_input) clear_stream();
    end
    if (produced > 0) pending_records[pending_records.size()-1].last_of_run = 1'b1;
  endfunction

  // accept transfers, predict and check at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_records.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: matched=%0b len=%0d last=%0b",
                     result_data.matched, result_data.record_length, result_data.last_of_run);
        end else begin
          want = pending_records.pop_front();
          if (result_data.matched !== want.matched ||
              result_data.record_length !== want.record_length ||
              result_data.last_of_run !== want.last_of_run) begin
            error_count++;
            if (error_count <= 10)
              $display("result mismatch: expected matched=%0b len=%0d last=%0b, got %0b %0d %0b",
                       want.matched, want.record_length, want.last_of_run,
                       result_data.matched, result_data.record_length, result_data.last_of_run);
          end
        end
      end
      if (byte_valid && !byte_stall) begin
        filter_byte(byte_data);
        accepted_count++;
        byte_taken = 1'b1;
      end
    end
  end

  // byte driver: bursts of random length with random gaps
  int unsigned burst_left, gap_left;
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_taken) begin
      byte_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        byte_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        byte_data  <= byte_queue.pop_front();
        byte_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // result receiver: its own stall pattern plus one long hold-off on request
  int unsigned hold_left, stall_run;
  bit          stall_on;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      hold_left      = HOLD_OFF_CYCLES;
      result_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_on = !stall_on;
        if (stall_on) stall_run = $urandom_range(1, 8);
        else if ($urandom_range(0, 4) == 0) stall_run = $urandom_range(40, 120);
        else stall_run = $urandom_range(1, 10);
      end
      stall_run--;
      result_stall <= stall_on;
    end
  end

  initial begin : watchdog
    #(TIMEOUT);
    $display("tb: FAIL");
    $finish;
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RECORD_MODE:    cfg_mode    = val[0];
      REG_KEY_BYTES:      cfg_key     = val;
      REG_KEY_LENGTH:     cfg_key_len = val[3:0];
      REG_PATTERN_BYTES:  cfg_pat     = val;
      REG_PATTERN_LENGTH: cfg_pat_len = val[3:0];
      REG_PREFIX_BYTES:   cfg_pfx     = val;
      REG_PREFIX_LENGTH:  cfg_pfx_len = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers carry noise
  task automatic program_filter(bit mode, bit [63:0] key, bit [3:0] key_len,
                                bit [63:0] pat, bit [3:0] pat_len,
                                bit [63:0] pfx, bit [3:0] pfx_len);
    write_reg(REG_RECORD_MODE,    {$urandom, 31'($urandom), mode});
    write_reg(REG_KEY_BYTES,      key);
    write_reg(REG_KEY_LENGTH,     {$urandom, 28'($urandom), key_len});
    write_reg(REG_PATTERN_BYTES,  pat);
    write_reg(REG_PATTERN_LENGTH, {$urandom, 28'($urandom), pat_len});
    write_reg(REG_PREFIX_BYTES,   pfx);
    write_reg(REG_PREFIX_LENGTH,  {$urandom, 28'($urandom), pfx_len});
    @(posedge clk);
  endtask

  // wait until every byte is taken and every record reported, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (accepted_count != queued_count || pending_records.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic bit [63:0] pack_text(string s);
    bit [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic void send_byte(bit [7:0] b, bit eoi);
    byte_item_t it;
    it.text_byte    = b;
    it.end_of_input = eoi;
    byte_queue.push_back(it);
    queued_count++;
  endfunction

  function automatic void send_text(string s, bit eoi_last = 1'b0);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_last && i == s.len() - 1);
  endfunction

  function automatic void send_word(bit [63:0] w, int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(w[8*i +: 8], 1'b0);
  endfunction

  function automatic void send_fill(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(8'(8'h61 + $urandom_range(0, 2)), 1'b0);
  endfunction

  // text biased toward the bytes of the key, pattern and prefix
  function automatic bit [7:0] noise_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 8'($urandom_range(0, 255));
    if (r < 7)  return CHAR_NUL;
    if (r < 10) return cfg_mode ? CHAR_SPACE : CHAR_NEWLINE;
    if (r < 40) return cfg_pat[8*$urandom_range(0, 7) +: 8];
    if (r < 55) return cfg_key[8*$urandom_range(0, 7) +: 8];
    if (r < 65) return cfg_pfx[8*$urandom_range(0, 7) +: 8];
    return 8'(8'h61 + $urandom_range(0, 2));
  endfunction

  function automatic void send_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(noise_byte(), $urandom_range(0, 149) == 0);
  endfunction

  // mostly well-formed records: key or prefix, text, pattern, text, newline
  function automatic void fill_stream(int unsigned count);
    int unsigned goal;
    goal = queued_count + count;
    while (queued_count < goal - 1) begin
      if (cfg_mode) begin
        if ($urandom_range(0, 9) != 0) send_word(cfg_key, eff_len(cfg_key_len, 1));
      end else if (cfg_pfx_len != 0 && $urandom_range(0, 2) != 0) begin
        send_word(cfg_pfx, eff_len(cfg_pfx_len, 0));
      end
      send_noise($urandom_range(0, 10));
      if ($urandom_range(0, 1) != 0) send_word(cfg_pat, eff_len(cfg_pat_len, 0));
      send_noise($urandom_range(0, 6));
      if (!cfg_mode && $urandom_range(0, 9) != 0) send_byte(CHAR_NEWLINE, 1'b0);
    end
    send_byte(noise_byte(), 1'b1);
  endfunction

  initial begin : stimulus
    cfg_mode    = MODE_LINE;
    cfg_key     = '0;
    cfg_key_len = 4'd1;
    cfg_pat     = '0;
    cfg_pat_len = 4'd0;
    cfg_pfx     = '0;
    cfg_pfx_len = 4'd0;
    clear_stream();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // line mode: prefix hit and miss, empty line, nul cutting the pattern, last line open
    program_filter(MODE_LINE, pack_text("K:"), 4'd1, pack_text("ab"), 4'd2,
                   pack_text("x"), 4'd1);
    send_text("xab\n");
    send_text("ab\n");
    send_byte(CHAR_NEWLINE, 1'b0);
    send_text("x");
    send_byte(CHAR_NUL, 1'b0);
    send_text("ab\n");
    send_byte(8'hff, 1'b1);
    drain();

    // record mode: text before the first key, nul as space, key on the final byte
    program_filter(MODE_RECORD, pack_text("K:"), 4'd2, 64'd0, 4'd0, pack_text("x"), 4'd1);
    send_text("z");
    send_byte(CHAR_NUL, 1'b0);
    send_text("K:a");
    send_byte(CHAR_NUL, 1'b0);
    send_text("K:K:", 1'b1);
    drain();

    program_filter(MODE_LINE, '0, 4'd1, pack_text("abc"), 4'd3, pack_text("a"), 4'd1);
    fill_stream(120);
    drain();
    program_filter(MODE_LINE, '0, 4'd1, pack_text("abcabcab"), 4'd8, '0, 4'd0);
    fill_stream(100);
    drain();
    program_filter(MODE_LINE, '0, 4'd1, '0, 4'd0, pack_text("ab cabca"), 4'd8);
    fill_stream(80);
    drain();
    // lengths above the limit act as eight
    program_filter(MODE_LINE, '0, 4'd1, pack_text("aabbaabb"), 4'd15,
                   pack_text("abcabcab"), 4'd15);
    fill_stream(60);
    drain();
    // pattern holding a nul never matches
    program_filter(MODE_LINE, '0, 4'd1, 64'h0000_0000_0062_0061, 4'd3, '0, 4'd0);
    fill_stream(50);
    drain();
    // prefix is ignored in record mode
    program_filter(MODE_RECORD, pack_text("K:"), 4'd2, pack_text("ab"), 4'd2,
                   pack_text("abc"), 4'd3);
    fill_stream(150);
    drain();
    // zero key length acts as one
    program_filter(MODE_RECORD, pack_text("K"), 4'd0, '0, 4'd0, '0, 4'd0);
    fill_stream(80);
    drain();
    program_filter(MODE_RECORD, pack_text("<REC>abc"), 4'd8, pack_text("abc"), 4'd3, '0, 4'd0);
    fill_stream(120);
    drain();
    program_filter(MODE_RECORD, '1, 4'd15, '1, 4'd8, '1, 4'd8);
    fill_stream(80);
    drain();
    // nul key never matches, so no record ever opens
    program_filter(MODE_RECORD, '0, 4'd1, '0, 4'd8, '0, 4'd0);
    fill_stream(30);
    drain();

    // results held off for a long stretch while bytes keep coming, then a sender pause
    program_filter(MODE_LINE, '0, 4'd1, pack_text("a"), 4'd1, '0, 4'd0);
    long_stall_req = 1'b1;
    fill_stream(75);
    drain();
    fill_stream(75);
    drain();

    // space key, also hit by nul bytes
    program_filter(MODE_RECORD, pack_text(" "), 4'd1, pack_text("a a"), 4'd3, '0, 4'd0);
    fill_stream(60);
    drain();

    // a line longer than the line cap
    program_filter(MODE_LINE, '0, 4'd1, pack_text("cab"), 4'd3, '0, 4'd0);
    send_fill(5000);
    send_text("\n");
    send_fill(20);
    send_text("c", 1'b1);
    drain();

    // key straddling the record cap, then a record far past the cap
    program_filter(MODE_RECORD, pack_text("K:"), 4'd2, pack_text("zz"), 4'd2, '0, 4'd0);
    send_text("K:");
    send_fill(REC_CAP - 3);
    send_text("K:");
    send_fill(REC_CAP + 100);
    send_text("zzabK:ab");
    send_text("x", 1'b1);
    drain();

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
